/* hw/rtl/tle_pkg.sv */
package tle_pkg;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LB       = 8'h5B;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DN       = 8'h42;
  localparam logic [7:0] CH_RT       = 8'h43;
  localparam logic [7:0] CH_LT       = 8'h44;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET
  } esc_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CR,
    ST_LF
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } tle_emit_t;

endpackage

/* hw/rtl/tle_in_if.sv */
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source(output valid, output in_byte, input ready);
  modport sink(input valid, input in_byte, output ready);
endinterface

/* hw/rtl/tle_out_if.sv */
interface tle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source(output valid, output out_char, output last, input ready);
  modport sink(input valid, input out_char, input last, output ready);
endinterface

/* hw/rtl/tle_store.sv */
module tle_store #(
  parameter int DEPTH  = 62,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] written;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

endmodule

/* hw/rtl/tle_ctrl.sv */
module tle_ctrl
  import tle_pkg::*;
#(
  parameter int LINE_LEN = 62,
  parameter int CUR_W    = 6,
  parameter int ADDR_W   = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  input  logic              out_free,
  output tle_emit_t         emit,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data
);

  seq_state_t state, state_next;
  esc_phase_t esc, esc_next;
  logic [CUR_W-1:0] cursor, cursor_next;
  logic [CUR_W-1:0] raw_count, raw_count_next;
  logic [CUR_W-1:0] idx, idx_next;
  logic             cr_seen, cr_seen_next;

  // shared incrementer/decrementer: cursor moves while editing, read index while emitting
  logic [CUR_W-1:0] step_a;
  logic             step_dec;
  logic [CUR_W-1:0] step_sum;

  logic fwd, go_l, go_r, put, printable, room;

  assign step_sum  = step_dec ? (step_a - CUR_W'(1)) : (step_a + CUR_W'(1));
  assign printable = (in_byte >= CH_PRINT_LO) && (in_byte <= CH_PRINT_HI);
  assign room      = (cursor < CUR_W'(LINE_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      esc       <= ESC_IDLE;
      cursor    <= '0;
      raw_count <= '0;
      idx       <= '0;
      cr_seen   <= 1'b0;
    end else begin
      state     <= state_next;
      esc       <= esc_next;
      cursor    <= cursor_next;
      raw_count <= raw_count_next;
      idx       <= idx_next;
      cr_seen   <= cr_seen_next;
    end
  end

  always_comb begin
    state_next     = state;
    esc_next       = esc;
    cursor_next    = cursor;
    raw_count_next = raw_count;
    idx_next       = idx;
    cr_seen_next   = cr_seen;
    in_ready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = cursor[ADDR_W-1:0];
    wr_data        = in_byte;
    rd_en          = 1'b0;
    rd_addr        = idx[ADDR_W-1:0];
    emit           = '0;
    step_a         = cursor;
    step_dec       = 1'b0;
    fwd            = 1'b0;
    go_l           = 1'b0;
    go_r           = 1'b0;
    put            = 1'b0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte == CH_LF && cr_seen) begin
            idx_next   = '0;
            state_next = (cursor == '0) ? ST_CR : ST_READ;
          end else begin
            fwd      = 1'b1;
            esc_next = ESC_IDLE;
            case (esc)
              ESC_BRACKET: begin
                fwd  = 1'b0;
                go_r = (in_byte == CH_RT);
                go_l = (in_byte == CH_LT);
              end
              ESC_SEEN: begin
                if (in_byte == CH_LB) begin
                  fwd      = 1'b0;
                  esc_next = ESC_BRACKET;
                end
              end
              default: ;
            endcase
            if (fwd) begin
              if (printable) begin
                put = 1'b1;
              end else if (in_byte == CH_BS) begin
                go_l = 1'b1;
              end else if (in_byte == CH_ESC) begin
                esc_next = ESC_SEEN;
              end
            end
            step_dec = go_l;
            wr_en    = put && room;
            if ((go_l && cursor != '0) || ((go_r || put) && room)) begin
              cursor_next = step_sum;
            end
            cr_seen_next   = (in_byte == CH_CR);
            raw_count_next = raw_count + CUR_W'(1);
            // overlong line: drop it
            if (raw_count == CUR_W'(LINE_LEN - 1)) begin
              cursor_next    = '0;
              raw_count_next = '0;
              esc_next       = ESC_IDLE;
              cr_seen_next   = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        step_a = idx;
        if (out_free) begin
          emit       = '{valid: 1'b1, data: rd_data, last: 1'b0};
          idx_next   = step_sum;
          state_next = (step_sum == cursor) ? ST_CR : ST_READ;
        end
      end
      ST_CR: begin
        if (out_free) begin
          emit       = '{valid: 1'b1, data: CH_CR, last: 1'b0};
          state_next = ST_LF;
        end
      end
      ST_LF: begin
        if (out_free) begin
          emit           = '{valid: 1'b1, data: CH_LF, last: 1'b1};
          cursor_next    = '0;
          raw_count_next = '0;
          esc_next       = ESC_IDLE;
          cr_seen_next   = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (idx < cursor))
    else $error("read index past cursor");

  a_lf_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LF && out_free) |=> (state == ST_IDLE && cursor == '0 && raw_count == '0))
    else $error("line state not cleared after LF");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("emit into occupied output register");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_IDLE && cursor < CUR_W'(LINE_LEN)))
    else $error("store write outside editing or past line end");
`endif

endmodule

/* hw/rtl/terminal_line_editor.sv */
// Console line editor. Raw bytes arrive on rx one transaction at a time and
// edit a line store at a cursor: printable bytes are written and advance the
// cursor, backspace and ESC [ D move left, ESC [ C moves right, everything
// else is dropped. A CR immediately followed by LF sends the store bytes
// 0..cursor-1 out on tx, then CR and LF with last set on the LF, and starts a
// new line; the store itself keeps its bytes and is cleared only by reset
// (per-entry written bits, so no clearing pass is needed after reset). A line
// reaching LINE_LEN raw bytes is discarded without output. While editing, rx
// is always ready. At a line end each emitted store byte takes a read on the
// store's read port, then a load of the output register through the shared
// incrementer; CR and LF follow, and every load waits while tx stalls. rx
// is not ready during that time. tx has its own output register, so the next
// rx byte is taken while the final LF still waits.
module terminal_line_editor
  import tle_pkg::*;
#(
  parameter int LINE_LEN = 62
) (
  input  logic      clk,
  input  logic      rst,
  tle_in_if.sink    rx,
  tle_out_if.source tx
);

  localparam int CUR_W  = $clog2(LINE_LEN + 1);
  localparam int ADDR_W = $clog2(LINE_LEN);

  tle_emit_t         emit;
  logic              out_free;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;

  // output register
  logic       out_valid;
  logic [7:0] out_data;
  logic       out_last;

  // take a new byte whenever the register is empty or being drained
  assign out_free    = !out_valid || tx.ready;
  assign tx.valid    = out_valid;
  assign tx.out_char = out_data;
  assign tx.last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold payload until the next load
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_data <= emit.data;
      out_last <= emit.last;
    end
  end

  tle_ctrl #(
    .LINE_LEN(LINE_LEN),
    .CUR_W   (CUR_W),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(rx.valid),
    .in_byte (rx.in_byte),
    .in_ready(rx.ready),
    .out_free(out_free),
    .emit    (emit),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tle_store #(
    .DEPTH (LINE_LEN),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
